FILE: design/twsp_pkg.sv
// Shared types and constants for the tile window stream planner.
// Used by the channel interfaces, the controller, the datapath, the output stage and the top level.
package twsp_pkg;

	// Window edge in cells and the bits that address a cell inside it.
	localparam int WINDOW   = 4;
	localparam int WIN_BITS = 2;
	// Line counters hold up to WINDOW lines.
	localparam int CNT_W    = WIN_BITS + 1;

	localparam int COORD_W  = 16;
	// Cell coordinates with room for the origin plus the window edge and a sign.
	localparam int CELL_W   = COORD_W + 2;
	localparam int GRID_W   = 11;
	localparam int TILE_W   = 17;
	localparam int IDX_W    = 16;
	localparam int PROD_W   = 2 * GRID_W;

	localparam logic [TILE_W-1:0] OFF_GRID = {TILE_W{1'b1}};

	localparam logic OP_MOVE       = 1'b0;
	localparam logic OP_INVALIDATE = 1'b1;

	localparam logic KIND_UPLOAD = 1'b0;
	localparam logic KIND_FETCH  = 1'b1;

	localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COLS,
		ST_ROWS
	} state_t;

	typedef struct packed {
		logic load;
		logic full;
		logic step;
		logic row_phase;
	} dp_cmd_t;

	typedef struct packed {
		logic jump;
		logic dx_zero;
		logic dy_zero;
		logic j_last;
		logic col_one;
		logic row_one;
		logic row_zero;
	} dp_status_t;

	typedef struct packed {
		logic valid;
		logic kind;
		logic flush;
		logic last;
	} emit_t;

endpackage

FILE: design/twsp_if.sv
// Valid/ready channel interfaces for the move commands and the fetch words.
// Depends on twsp_pkg for field widths.
interface twsp_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  opcode;
	logic signed [twsp_pkg::COORD_W-1:0]   new_cell_x;
	logic signed [twsp_pkg::COORD_W-1:0]   new_cell_y;

	modport source(output valid, opcode, new_cell_x, new_cell_y, input ready);
	modport sink(input valid, opcode, new_cell_x, new_cell_y, output ready);
endinterface

interface twsp_res_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic signed [twsp_pkg::TILE_W-1:0]    tile_index;
	logic [2*twsp_pkg::WIN_BITS-1:0]       slot;
	logic                                  flush_cache;
	logic                                  last;

	modport source(output valid, kind, tile_index, slot, flush_cache, last, input ready);
	modport sink(input valid, kind, tile_index, slot, flush_cache, last, output ready);
endinterface

FILE: design/twsp_ctrl.sv
// Controller of the planner: sequences full reloads, column fetches and row fetches.
// Depends on twsp_pkg; drives twsp_dp through dp_cmd_t and reads dp_status_t.
module twsp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_opcode,
	input  twsp_pkg::dp_status_t  status,
	input  logic                  gen_ready,
	output twsp_pkg::dp_cmd_t     cmd,
	output twsp_pkg::emit_t       emit
);

	twsp_pkg::state_t state_q, state_next;
	logic force_q;
	logic full_q;
	logic accept, move, inval, load_full;

	assign accept    = in_valid && (state_q == twsp_pkg::ST_IDLE);
	assign move      = accept && (in_opcode == twsp_pkg::OP_MOVE);
	assign inval     = accept && (in_opcode == twsp_pkg::OP_INVALIDATE);
	assign load_full = force_q || status.jump;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			twsp_pkg::ST_IDLE: begin
				if (move) begin
					if (load_full)
						state_next = twsp_pkg::ST_ROWS;
					else if (!status.dx_zero)
						state_next = twsp_pkg::ST_COLS;
					else if (!status.dy_zero)
						state_next = twsp_pkg::ST_ROWS;
				end
			end
			twsp_pkg::ST_COLS: begin
				if (gen_ready && status.j_last && status.col_one)
					state_next = status.row_zero ? twsp_pkg::ST_IDLE : twsp_pkg::ST_ROWS;
			end
			twsp_pkg::ST_ROWS: begin
				if (gen_ready && status.j_last && status.row_one)
					state_next = twsp_pkg::ST_IDLE;
			end
			default: state_next = twsp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == twsp_pkg::ST_IDLE);
		cmd.load      = move;
		cmd.full      = load_full;
		cmd.row_phase = (state_q == twsp_pkg::ST_ROWS);
		emit.valid    = (state_q == twsp_pkg::ST_COLS) || (state_q == twsp_pkg::ST_ROWS);
		cmd.step      = emit.valid && gen_ready;
		emit.kind     = full_q ? twsp_pkg::KIND_UPLOAD : twsp_pkg::KIND_FETCH;
		if (state_q == twsp_pkg::ST_COLS)
			emit.last = status.j_last && status.col_one && status.row_zero;
		else
			emit.last = status.j_last && status.row_one;
		emit.flush    = full_q && emit.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twsp_pkg::ST_IDLE;
			force_q <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (inval)
				force_q <= 1'b1;
			else if (move)
				force_q <= 1'b0;
			if (move)
				full_q <= load_full;
		end
	end

endmodule

FILE: design/twsp_dp.sv
// Datapath of the planner: window origin, line and column counters, cell coordinate generation.
// Depends on twsp_pkg; commanded by twsp_ctrl.
module twsp_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  twsp_pkg::dp_cmd_t                    cmd,
	input  logic signed [twsp_pkg::COORD_W-1:0]  new_x,
	input  logic signed [twsp_pkg::COORD_W-1:0]  new_y,
	output twsp_pkg::dp_status_t                 status,
	output logic signed [twsp_pkg::CELL_W-1:0]   cell_x,
	output logic signed [twsp_pkg::CELL_W-1:0]   cell_y
);

	localparam int CW = twsp_pkg::CELL_W;
	localparam int NW = twsp_pkg::CNT_W;
	localparam int JW = twsp_pkg::WIN_BITS;
	localparam logic signed [CW-1:0] WinS   = CW'(twsp_pkg::WINDOW);
	localparam logic signed [CW-1:0] OffS   = CW'(twsp_pkg::WINDOW - 1);
	localparam logic signed [CW-1:0] OneS   = CW'(1);
	localparam logic [JW-1:0]        JLast  = JW'(twsp_pkg::WINDOW - 1);
	localparam logic [NW-1:0]        CntWin = NW'(twsp_pkg::WINDOW);
	localparam logic [NW-1:0]        CntOne = NW'(1);

	logic signed [twsp_pkg::COORD_W-1:0] org_x_q, org_y_q;
	logic signed [CW-1:0] col_line_q, row_line_q;
	logic col_up_q, row_up_q, row_off_q;
	logic [NW-1:0] col_cnt_q, row_cnt_q;
	logic [JW-1:0] j_q;

	logic signed [CW-1:0] x_ext, y_ext, ox_ext, oy_ext, dx, dy, adx, ady;
	logic signed [CW-1:0] j_ext, col_x, row_y;
	logic dx_pos, dy_pos;

	assign x_ext  = CW'(new_x);
	assign y_ext  = CW'(new_y);
	assign ox_ext = CW'(org_x_q);
	assign oy_ext = CW'(org_y_q);
	assign dx     = x_ext - ox_ext;
	assign dy     = y_ext - oy_ext;
	assign adx    = dx[CW-1] ? -dx : dx;
	assign ady    = dy[CW-1] ? -dy : dy;
	assign dx_pos = !dx[CW-1] && (dx != '0);
	assign dy_pos = !dy[CW-1] && (dy != '0);

	always_comb begin
		status.jump     = (dx >= WinS) || (dx <= -WinS) || (dy >= WinS) || (dy <= -WinS);
		status.dx_zero  = (dx == '0);
		status.dy_zero  = (dy == '0);
		status.j_last   = (j_q == JLast);
		status.col_one  = (col_cnt_q == CntOne);
		status.row_one  = (row_cnt_q == CntOne);
		status.row_zero = (row_cnt_q == '0);
	end

	// Column phase walks x lines at the new origin's rows; row phase walks y lines.
	assign j_ext  = CW'(j_q);
	assign col_x  = col_line_q + (col_up_q ? OffS : '0);
	assign row_y  = row_line_q + (row_off_q ? OffS : '0);
	assign cell_x = cmd.row_phase ? (ox_ext + j_ext) : col_x;
	assign cell_y = cmd.row_phase ? row_y : (oy_ext + j_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q   <= '0;
			org_y_q   <= '0;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			j_q       <= '0;
		end else if (cmd.load) begin
			org_x_q   <= new_x;
			org_y_q   <= new_y;
			j_q       <= '0;
			col_cnt_q <= cmd.full ? '0 : adx[NW-1:0];
			row_cnt_q <= cmd.full ? CntWin : ady[NW-1:0];
		end else if (cmd.step) begin
			j_q <= j_q + JW'(1);
			if (j_q == JLast) begin
				if (cmd.row_phase)
					row_cnt_q <= row_cnt_q - CntOne;
				else
					col_cnt_q <= col_cnt_q - CntOne;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_up_q   <= dx_pos;
			col_line_q <= dx_pos ? (ox_ext + OneS) : (ox_ext - OneS);
			row_up_q   <= cmd.full || dy_pos;
			row_off_q  <= !cmd.full && dy_pos;
			if (cmd.full)
				row_line_q <= y_ext;
			else
				row_line_q <= dy_pos ? (oy_ext + OneS) : (oy_ext - OneS);
		end else if (cmd.step && (j_q == JLast)) begin
			if (cmd.row_phase)
				row_line_q <= row_up_q ? (row_line_q + OneS) : (row_line_q - OneS);
			else
				col_line_q <= col_up_q ? (col_line_q + OneS) : (col_line_q - OneS);
		end
	end

endmodule

FILE: design/twsp_out.sv
// Output stage of the planner: grid index, window slot and the result register.
// Depends on twsp_pkg and the result channel interface in twsp_if.
module twsp_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  twsp_pkg::emit_t                     emit,
	input  logic signed [twsp_pkg::CELL_W-1:0]  cell_x,
	input  logic signed [twsp_pkg::CELL_W-1:0]  cell_y,
	input  logic [twsp_pkg::GRID_W-1:0]         grid_width,
	input  logic [twsp_pkg::GRID_W-1:0]         grid_height,
	output logic                                gen_ready,
	twsp_res_if.source                          res
);

	localparam int CW = twsp_pkg::CELL_W;
	localparam int GW = twsp_pkg::GRID_W;
	localparam int PW = twsp_pkg::PROD_W;
	localparam int SW = 2 * twsp_pkg::WIN_BITS;

	logic v_s1, kind_s1, flush_s1, last_s1;
	logic signed [CW-1:0] cx_s1, cy_s1;

	logic out_valid_q, kind_q, flush_q, last_q;
	logic [twsp_pkg::TILE_W-1:0] tile_q;
	logic [SW-1:0] slot_q;

	logic out_adv, s1_adv, off_grid;
	logic [PW-1:0] idx;

	assign out_adv   = !out_valid_q || res.ready;
	assign s1_adv    = !v_s1 || out_adv;
	assign gen_ready = s1_adv;

	assign off_grid = cx_s1[CW-1] || cy_s1[CW-1] ||
		(cx_s1[CW-2:0] >= (CW-1)'(grid_width)) ||
		(cy_s1[CW-2:0] >= (CW-1)'(grid_height));
	// In range both coordinates are below 2048, so the low bits are exact.
	assign idx = PW'(cy_s1[GW-1:0]) * PW'(grid_width) + PW'(cx_s1[GW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv)
				v_s1 <= emit.valid;
			if (out_adv)
				out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cx_s1    <= cell_x;
			cy_s1    <= cell_y;
			kind_s1  <= emit.kind;
			flush_s1 <= emit.flush;
			last_s1  <= emit.last;
		end
		if (out_adv) begin
			kind_q  <= kind_s1;
			flush_q <= flush_s1;
			last_q  <= last_s1;
			tile_q  <= off_grid ? twsp_pkg::OFF_GRID
				: {1'b0, idx[twsp_pkg::IDX_W-1:0]};
			// Positive modulo of a power-of-two window is the low bits.
			slot_q  <= {cy_s1[twsp_pkg::WIN_BITS-1:0], cx_s1[twsp_pkg::WIN_BITS-1:0]};
		end
	end

	assign res.valid       = out_valid_q;
	assign res.kind        = kind_q;
	assign res.tile_index  = $signed(tile_q);
	assign res.slot        = slot_q;
	assign res.flush_cache = flush_q;
	assign res.last        = last_q;

endmodule

FILE: design/tile_window_stream_planner_unit.sv
// Tile window stream planner: turns camera cell moves into tile fetch words.
// The first word of a move is registered through the controller state, the s1 stage and the result register.
// Throughput: one word per cycle while the consumer does not stall; a move holds the input until every word
// it causes (up to 24) has been generated, as the single coordinate generator makes them one at a time, and
// output back-pressure holds it longer. An invalidate or a still move with no reload pending makes no words.
// Reset clears the origin, the forced-reload flag and both grid sizes; there is no clearing pass.
module tile_window_stream_planner_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	twsp_cmd_if.sink                     cmd,
	twsp_res_if.source                   res,
	input  logic                         wr_en,
	input  logic [0:0]                   wr_index,
	input  logic [twsp_pkg::GRID_W-1:0]  wr_data
);

	// Grid size registers. They must be written only while the planner is idle; the block itself does not enforce this.
	logic [twsp_pkg::GRID_W-1:0] grid_width_q, grid_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= '0;
			grid_height_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				twsp_pkg::REG_GRID_WIDTH:  grid_width_q  <= wr_data;
				twsp_pkg::REG_GRID_HEIGHT: grid_height_q <= wr_data;
			endcase
		end
	end

	// The controller decides between a full reload, column fetches and row fetches;
	// the datapath holds the origin and walks the exposed lines one cell per cycle unless the output stalls.
	twsp_pkg::dp_cmd_t    dp_cmd;
	twsp_pkg::dp_status_t dp_status;
	twsp_pkg::emit_t      emit;
	logic                 gen_ready;
	logic signed [twsp_pkg::CELL_W-1:0] cell_x, cell_y;

	twsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.in_opcode (cmd.opcode),
		.status    (dp_status),
		.gen_ready (gen_ready),
		.cmd       (dp_cmd),
		.emit      (emit)
	);

	twsp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.new_x  (cmd.new_cell_x),
		.new_y  (cmd.new_cell_y),
		.status (dp_status),
		.cell_x (cell_x),
		.cell_y (cell_y)
	);

	// The output stage maps each cell to its grid tile and window slot and holds the
	// word until the consumer takes it, so generation stalls cleanly on back-pressure.
	twsp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit        (emit),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.gen_ready   (gen_ready),
		.res         (res)
	);

endmodule

FILE: tb/sv/tile_fetch_checker.sv
`timescale 1ns / 100ps
// Checker for the tile window stream planner: it predicts the fetch words of every accepted
// move and compares each accepted word with the oldest prediction.
// Depends on twsp_pkg and the channel interfaces in twsp_if.sv.
module tile_fetch_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	twsp_cmd_if                          cmd,
	twsp_res_if                          res,
	input  logic                         wr_en,
	input  logic [0:0]                   wr_index,
	input  logic [twsp_pkg::GRID_W-1:0]  wr_data,
	output int                           mismatches,
	output int                           outstanding,
	output int                           words_checked,
	output int                           reloads_planned
);
	import twsp_pkg::*;

	localparam int SLOT_W = 2 * WIN_BITS;

	typedef struct packed {
		logic              kind;
		logic [TILE_W-1:0] tile_index;
		logic [SLOT_W-1:0] slot;
		logic              flush_cache;
		logic              last;
	} fetch_word_t;

	fetch_word_t                 fetch_queue[$];
	fetch_word_t                 want;
	fetch_word_t                 got;
	logic signed [COORD_W-1:0]   origin_x;
	logic signed [COORD_W-1:0]   origin_y;
	logic                        reload_armed;
	logic [GRID_W-1:0]           grid_cols;
	logic [GRID_W-1:0]           grid_rows;

	// Positive remainder of a cell coordinate within the window.
	function automatic int cell_mod(input int v);
		int r;
		r = v % WINDOW;
		if (r < 0)
			r += WINDOW;
		return r;
	endfunction

	function automatic fetch_word_t fetch_word(input logic kind, input int cx, input int cy,
			input logic flush);
		fetch_word_t w;
		int cols;
		int rows;
		cols = grid_cols;
		rows = grid_rows;
		w.kind = kind;
		if (cx < 0 || cy < 0 || cx >= cols || cy >= rows)
			w.tile_index = OFF_GRID;
		else
			w.tile_index = {1'b0, IDX_W'(cy * cols + cx)};
		w.slot = SLOT_W'(cell_mod(cx) + WINDOW * cell_mod(cy));
		w.flush_cache = flush;
		w.last = 1'b0;
		return w;
	endfunction

	task automatic plan_fetches(input logic op, input logic signed [COORD_W-1:0] nx,
			input logic signed [COORD_W-1:0] ny);
		fetch_word_t batch[$];
		int x;
		int y;
		int ox;
		int oy;
		int i;
		int j;
		if (op == OP_INVALIDATE) begin
			reload_armed = 1'b1;
			return;
		end
		x = nx;
		y = ny;
		ox = origin_x;
		oy = origin_y;
		if (reload_armed || x - ox >= WINDOW || ox - x >= WINDOW ||
				y - oy >= WINDOW || oy - y >= WINDOW) begin
			for (j = 0; j < WINDOW; j++)
				for (i = 0; i < WINDOW; i++)
					batch.push_back(fetch_word(KIND_UPLOAD, x + i, y + j,
						i == WINDOW - 1 && j == WINDOW - 1));
			reloads_planned++;
		end else begin
			// Newly exposed columns first, then rows, each line top to bottom or left to right.
			if (x > ox) begin
				for (i = ox + 1; i <= x; i++)
					for (j = 0; j < WINDOW; j++)
						batch.push_back(fetch_word(KIND_FETCH, i + WINDOW - 1, y + j, 1'b0));
			end else if (x < ox) begin
				for (i = ox - 1; i >= x; i--)
					for (j = 0; j < WINDOW; j++)
						batch.push_back(fetch_word(KIND_FETCH, i, y + j, 1'b0));
			end
			if (y > oy) begin
				for (i = oy + 1; i <= y; i++)
					for (j = 0; j < WINDOW; j++)
						batch.push_back(fetch_word(KIND_FETCH, x + j, i + WINDOW - 1, 1'b0));
			end else if (y < oy) begin
				for (i = oy - 1; i >= y; i--)
					for (j = 0; j < WINDOW; j++)
						batch.push_back(fetch_word(KIND_FETCH, x + j, i, 1'b0));
			end
		end
		reload_armed = 1'b0;
		origin_x = nx;
		origin_y = ny;
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			fetch_queue.push_back(batch[k]);
	endtask

	task automatic flag_field(input string field, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		$display("%0t: word %0d, %s mismatch: expected %0d, got %0d",
			$time, words_checked, field, want_v, got_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_queue.delete();
			origin_x = '0;
			origin_y = '0;
			reload_armed = 1'b0;
			grid_cols = '0;
			grid_rows = '0;
			mismatches = 0;
			outstanding = 0;
			words_checked = 0;
			reloads_planned = 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_GRID_WIDTH)
					grid_cols = wr_data;
				else
					grid_rows = wr_data;
			end
			if (cmd.valid && cmd.ready)
				plan_fetches(cmd.opcode, cmd.new_cell_x, cmd.new_cell_y);
			if (res.valid && res.ready) begin
				got.kind = res.kind;
				got.tile_index = res.tile_index;
				got.slot = res.slot;
				got.flush_cache = res.flush_cache;
				got.last = res.last;
				if (fetch_queue.size() == 0) begin
					$display("%0t: unexpected word: expected none, got kind %0d tile %0d slot %0d",
						$time, got.kind, $signed(got.tile_index), got.slot);
					mismatches++;
				end else begin
					want = fetch_queue.pop_front();
					if (got.kind !== want.kind)
						flag_field("kind", want.kind, got.kind);
					if (got.tile_index !== want.tile_index)
						flag_field("tile_index", $signed(want.tile_index),
							$signed(got.tile_index));
					if (got.slot !== want.slot)
						flag_field("slot", want.slot, got.slot);
					if (got.flush_cache !== want.flush_cache)
						flag_field("flush_cache", want.flush_cache, got.flush_cache);
					if (got.last !== want.last)
						flag_field("last", want.last, got.last);
				end
				words_checked++;
			end
			outstanding = fetch_queue.size();
		end
	end

endmodule

FILE: tb/sv/tile_window_stream_planner_unit_tb.sv
`timescale 1ns / 100ps
// Top of the tile window stream planner testbench: clock, reset, grid size writes, move
// stimulus and the output ready pattern. Depends on twsp_pkg, twsp_if.sv, the planner and
// tile_fetch_checker, which does all prediction and comparison.
module tile_window_stream_planner_unit_tb;
	import twsp_pkg::*;

	localparam int CLK_PERIOD   = 20;
	// This limit is several times the length of the slowest correct run.
	localparam int LIMIT_CYCLES = 2_000_000;
	// Margin after the last predicted word; it covers a still move or invalidate and the output registers.
	localparam int DRAIN_TAIL   = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 68;
	localparam int PHASES       = 6;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [0:0]         wr_index;
	logic [GRID_W-1:0]  wr_data;

	twsp_cmd_if cmd();
	twsp_res_if res();

	int mismatches;
	int outstanding;
	int words_checked;
	int reloads_planned;

	// Stimulus bookkeeping. The current origin is the last cell a move was offered for, so
	// that most random moves are short steps from it, the way a camera really moves.
	logic signed [COORD_W-1:0] cur_x;
	logic signed [COORD_W-1:0] cur_y;
	int  cols_now;
	int  rows_now;
	int  moves_sent;
	int  invalidates_sent;
	// When steady is set neither side idles; squeeze_req asks the receiver for one long hold.
	bit  steady;
	bit  squeeze_req;

	tile_window_stream_planner_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	tile_fetch_checker fetch_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.res             (res),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.words_checked   (words_checked),
		.reloads_planned (reloads_planned)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Idle length shared by both sides: mostly none, often a short one, now and then a
	// long one. Inside a steady stretch there is no idling at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 93)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 30));
	endfunction

	// Receiver. Every cycle it either keeps stalling or raises ready, and after a ready
	// cycle it may pick a new stall. The one long hold is counted here too, while the
	// sender keeps offering moves, so the planner backs up and drops cmd.ready.
	initial begin
		int stall;
		bit squeezed;
		stall = 0;
		squeezed = 1'b0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				res.ready <= 1'b0;
				stall--;
			end else begin
				res.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// Offers one command and returns at the edge where it is accepted. Valid is only
	// lowered when a gap is actually taken, so back-to-back commands keep it high.
	task automatic offer(input logic op, input logic signed [COORD_W-1:0] nx,
			input logic signed [COORD_W-1:0] ny);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.opcode <= op;
		cmd.new_cell_x <= nx;
		cmd.new_cell_y <= ny;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		if (op == OP_MOVE) begin
			moves_sent++;
			cur_x = nx;
			cur_y = ny;
		end else begin
			invalidates_sent++;
		end
	endtask

	task automatic move_to(input int x, input int y);
		offer(OP_MOVE, COORD_W'(x), COORD_W'(y));
	endtask

	// The coordinates of an invalidate are ignored by the planner, so they carry noise.
	task automatic invalidate();
		offer(OP_INVALIDATE, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	// Grid sizes are only written while the planner is idle. Enable stays high across both
	// writes and drops once afterwards.
	task automatic set_grid(input int cols, input int rows);
		wr_en <= 1'b1;
		wr_index <= REG_GRID_WIDTH;
		wr_data <= GRID_W'(cols);
		@(posedge clk);
		wr_index <= REG_GRID_HEIGHT;
		wr_data <= GRID_W'(rows);
		@(posedge clk);
		wr_en <= 1'b0;
		cols_now = cols;
		rows_now = rows;
	endtask

	// Stops offering and waits until every predicted word has been taken, plus a tail for
	// work that produces no words and for any stray word the planner might still emit.
	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Random moves. Most are short camera steps (up to four cells, so the jump boundary is
	// hit as well), some are jumps that land near the grid, a few invalidates and still
	// moves, and the rest are fully random coordinates as noise.
	task automatic run_random(input int count);
		int r;
		int dx;
		int dy;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				invalidate();
			end else if (r < 12) begin
				offer(OP_MOVE, cur_x, cur_y);
			end else if (r < 72) begin
				dx = $urandom_range(0, 8);
				dy = $urandom_range(0, 8);
				dx -= 4;
				dy -= 4;
				case ($urandom_range(0, 2))
					0: dy = 0;
					1: dx = 0;
					default: ;
				endcase
				move_to(int'(cur_x) + dx, int'(cur_y) + dy);
			end else if (r < 90) begin
				move_to(int'($urandom_range(0, cols_now + 8)) - 4,
					int'($urandom_range(0, rows_now + 8)) - 4);
			end else begin
				offer(OP_MOVE, COORD_W'($urandom), COORD_W'($urandom));
			end
		end
	endtask

	initial begin
		int phase_cols[PHASES];
		int phase_rows[PHASES];
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_GRID_WIDTH;
		wr_data <= '0;
		cmd.valid <= 1'b0;
		cmd.opcode <= OP_MOVE;
		cmd.new_cell_x <= '0;
		cmd.new_cell_y <= '0;
		cur_x = '0;
		cur_y = '0;
		cols_now = 0;
		rows_now = 0;
		moves_sent = 0;
		invalidates_sent = 0;
		steady = 1'b0;
		squeeze_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on a small 16 x 12 grid.
		set_grid(16, 12);
		move_to(0, 0);               // same origin right after reset: no words
		move_to(1, 0);               // one new column on the right
		move_to(0, 0);               // one new column on the left
		move_to(0, 2);               // two new rows below
		move_to(0, -1);              // three rows above, the top one off the grid
		move_to(3, 2);               // three columns and three rows: the longest fetch list
		move_to(-1, 2);              // exactly four cells left counts as a jump
		invalidate();
		move_to(-1, 2);              // same cell, but the invalidate forces a reload
		invalidate();
		invalidate();
		move_to(0, 3);               // short step turned into a reload
		move_to(13, 9);              // window straddles the right and bottom grid edges
		move_to(32767, 32767);       // coordinates at the top of the range
		move_to(32764, 32764);       // short step back near the top
		move_to(-32768, -32768);     // bottom of the range
		move_to(-32765, -32768);
		move_to(-32765, -32765);
		move_to(32767, -32768);
		drain();
		// Empty grid: every tile is off the grid.
		set_grid(0, 0);
		move_to(5, 5);
		move_to(6, 5);
		drain();
		// Largest register values: tile indexes wrap past 16 bits.
		set_grid(2047, 2047);
		move_to(2040, 2040);
		move_to(2043, 2043);
		drain();

		// Random phases, each on its own grid, from degenerate to the largest sizes.
		phase_cols = '{1, 1024, 2047, 16, 0, 0};
		phase_rows = '{1, 1024, 2047, 12, 0, 0};
		phase_cols[PHASES - 1] = $urandom_range(0, 2047);
		phase_rows[PHASES - 1] = $urandom_range(0, 2047);
		for (int p = 0; p < PHASES; p++) begin
			set_grid(phase_cols[p], phase_rows[p]);
			steady = (p == 1 || p == 3);
			// The long receiver hold lands on the busy 16 x 12 phase.
			if (p == 3)
				squeeze_req <= 1'b1;
			run_random(PHASE_ITEMS);
			drain();
		end

		$display("tb: %0d moves and %0d invalidates on %0d grid sizes, %0d words checked",
			moves_sent, invalidates_sent, PHASES + 3, words_checked);
		$display("tb: %0d full reloads, one %0d cycle output hold", reloads_planned,
			HOLD_CYCLES);
		if (outstanding != 0)
			$display("%0t: %0d expected words never arrived", $time, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("tb: failure");
		$finish;
	end

endmodule
